// ===== sv/swept_aabb_collision_response_defines.svh =====
// ---------------------------------------------------------------------------
// Swept AABB collision response: assertion macros
// Concurrent check wrappers used by the top level; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef SWEPT_AABB_COLLISION_RESPONSE_DEFINES_SVH
`define SWEPT_AABB_COLLISION_RESPONSE_DEFINES_SVH

`ifndef SYNTHESIS
`define SABB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sabb check failed");
`define SABB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sabb check failed");
`else
`define SABB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SABB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/sabb_pkg.sv =====
// ---------------------------------------------------------------------------
// Swept AABB collision package
// Shared widths, constants, sideband types and saturation helper.
// ---------------------------------------------------------------------------
package sabb_pkg;

   localparam int FRAC_BITS = 16;
   localparam logic [31:0] PUSH_OUT = 32'(((1 << FRAC_BITS) + 5) / 10);

   localparam logic [15:0] FRAME_TIME_RESET = 16'd1092;

   localparam int DIV_STEPS = 24;   // quotient bits below the saturation limit
   localparam int QUO_W     = 24;
   localparam int DEN_W     = 48;   // |rv * dt|
   localparam int NUM_W     = 35;   // signed slab distance
   localparam int NMAG_W    = 34;
   localparam int SLABS     = 4;

   localparam int SLAB_NX = 0;
   localparam int SLAB_FX = 1;
   localparam int SLAB_NY = 2;
   localparam int SLAB_FY = 3;

   localparam logic signed [31:0] T_ONE = 32'sd65536;
   localparam logic [31:0]        T_BIG = 32'd1073741824;

   localparam logic signed [1:0] NORM_ZERO = 2'sb00;
   localparam logic signed [1:0] NORM_POS  = 2'sb01;
   localparam logic signed [1:0] NORM_NEG  = 2'sb11;

   typedef struct packed {
      logic signed [31:0] mx;
      logic signed [31:0] my;
      logic [31:0]        mw;
      logic [31:0]        mh;
      logic signed [31:0] mvx;
      logic signed [31:0] mvy;
   } geo_type;

   typedef struct packed {
      geo_type          geo;
      logic [32:0]      rvx_mag;
      logic [32:0]      rvy_mag;
      logic             rvx_neg;
      logic             rvy_neg;
      logic             dx_neg;
      logic             dy_neg;
      logic             early_miss;
      logic [SLABS-1:0] sat;
      logic [SLABS-1:0] neg;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [36:0] hi;
      logic signed [36:0] lo;
      hi = 37'sd2147483647;
      lo = -37'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== sv/sabb_prep.sv =====
// ---------------------------------------------------------------------------
// Swept AABB setup stages
// Relative motion, sweep step, slab distances, magnitudes and special cases.
// ---------------------------------------------------------------------------
module sabb_prep (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic [15:0]                           frame_time,
   input  logic signed [31:0]                    mover_x,
   input  logic signed [31:0]                    mover_y,
   input  logic [63:0]                           mover_size,
   input  logic signed [31:0]                    mover_vx,
   input  logic signed [31:0]                    mover_vy,
   input  logic signed [31:0]                    target_x,
   input  logic signed [31:0]                    target_y,
   input  logic [63:0]                           target_size,
   input  logic signed [31:0]                    target_vx,
   input  logic signed [31:0]                    target_vy,
   input  logic                                  target_active,
   output logic                                  out_valid,
   output logic [sabb_pkg::SLABS-1:0][sabb_pkg::DEN_W-1:0] out_rem,
   output logic [1:0][sabb_pkg::DEN_W-1:0]       out_den,
   output sabb_pkg::side_type                    out_side
);

   // stage 1: relative position and velocity
   logic                s1_valid_ff;
   sabb_pkg::geo_type   s1_geo_ff;
   logic signed [32:0]  s1_px_ff, s1_py_ff, s1_rvx_ff, s1_rvy_ff;
   logic [31:0]         s1_tw_ff, s1_th_ff;
   logic                s1_active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_geo_ff.mx  <= mover_x;
         s1_geo_ff.my  <= mover_y;
         s1_geo_ff.mw  <= mover_size[31:0];
         s1_geo_ff.mh  <= mover_size[63:32];
         s1_geo_ff.mvx <= mover_vx;
         s1_geo_ff.mvy <= mover_vy;
         s1_px_ff      <= 33'(mover_x) - 33'(target_x);
         s1_py_ff      <= 33'(mover_y) - 33'(target_y);
         s1_rvx_ff     <= 33'(mover_vx) - 33'(target_vx);
         s1_rvy_ff     <= 33'(mover_vy) - 33'(target_vy);
         s1_tw_ff      <= target_size[31:0];
         s1_th_ff      <= target_size[63:32];
         s1_active_ff  <= target_active;
      end
   end

   // stage 2: sweep step d = rv * dt and signed slab distances
   logic signed [49:0]       dx_full, dy_full;
   logic                     s2_valid_ff;
   sabb_pkg::geo_type        s2_geo_ff;
   logic signed [sabb_pkg::NUM_W-1:0] s2_num_ff [sabb_pkg::SLABS];
   logic signed [48:0]       s2_den_ff [2];
   logic [32:0]              s2_rvx_mag_ff, s2_rvy_mag_ff;
   logic                     s2_rvx_neg_ff, s2_rvy_neg_ff;
   logic                     s2_rv_zero_ff, s2_active_ff;

   assign dx_full = s1_rvx_ff * $signed({1'b0, frame_time});
   assign dy_full = s1_rvy_ff * $signed({1'b0, frame_time});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_geo_ff <= s1_geo_ff;
         s2_num_ff[sabb_pkg::SLAB_NX] <= -(35'(s1_px_ff) + 35'(s1_geo_ff.mw));
         s2_num_ff[sabb_pkg::SLAB_FX] <= 35'(s1_tw_ff) - 35'(s1_px_ff);
         s2_num_ff[sabb_pkg::SLAB_NY] <= -(35'(s1_py_ff) + 35'(s1_geo_ff.mh));
         s2_num_ff[sabb_pkg::SLAB_FY] <= 35'(s1_th_ff) - 35'(s1_py_ff);
         s2_den_ff[0]  <= dx_full[48:0];
         s2_den_ff[1]  <= dy_full[48:0];
         s2_rvx_mag_ff <= s1_rvx_ff[32] ? 33'(-s1_rvx_ff) : 33'(s1_rvx_ff);
         s2_rvy_mag_ff <= s1_rvy_ff[32] ? 33'(-s1_rvy_ff) : 33'(s1_rvy_ff);
         s2_rvx_neg_ff <= s1_rvx_ff[32];
         s2_rvy_neg_ff <= s1_rvy_ff[32];
         s2_rv_zero_ff <= (s1_rvx_ff == '0) && (s1_rvy_ff == '0);
         s2_active_ff  <= s1_active_ff;
      end
   end

   // stage 3: magnitudes and signs
   logic                      s3_valid_ff;
   sabb_pkg::geo_type         s3_geo_ff;
   logic [sabb_pkg::NMAG_W-1:0] s3_nmag_ff [sabb_pkg::SLABS];
   logic [sabb_pkg::SLABS-1:0]  s3_nneg_ff;
   logic [sabb_pkg::DEN_W-1:0]  s3_dmag_ff [2];
   logic [1:0]                s3_dneg_ff;
   logic [32:0]               s3_rvx_mag_ff, s3_rvy_mag_ff;
   logic                      s3_rvx_neg_ff, s3_rvy_neg_ff;
   logic                      s3_rv_zero_ff, s3_active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < sabb_pkg::SLABS; i++) begin
            s3_nmag_ff[i] <= s2_num_ff[i][sabb_pkg::NUM_W-1] ?
                             sabb_pkg::NMAG_W'(-s2_num_ff[i]) :
                             sabb_pkg::NMAG_W'(s2_num_ff[i]);
            s3_nneg_ff[i] <= s2_num_ff[i][sabb_pkg::NUM_W-1];
         end
         for (int a = 0; a < 2; a++) begin
            s3_dmag_ff[a] <= s2_den_ff[a][48] ? sabb_pkg::DEN_W'(-s2_den_ff[a]) :
                                                sabb_pkg::DEN_W'(s2_den_ff[a]);
            s3_dneg_ff[a] <= s2_den_ff[a][48];
         end
         s3_geo_ff     <= s2_geo_ff;
         s3_rvx_mag_ff <= s2_rvx_mag_ff;
         s3_rvy_mag_ff <= s2_rvy_mag_ff;
         s3_rvx_neg_ff <= s2_rvx_neg_ff;
         s3_rvy_neg_ff <= s2_rvy_neg_ff;
         s3_rv_zero_ff <= s2_rv_zero_ff;
         s3_active_ff  <= s2_active_ff;
      end
   end

   // stage 4: saturation and 0/0 detection, divider seed
   logic [sabb_pkg::SLABS-1:0] sat_in, nan_in, neg_in;
   logic [sabb_pkg::DEN_W-1:0] shifted [sabb_pkg::SLABS];
   logic                       s4_valid_ff;
   logic [sabb_pkg::SLABS-1:0][sabb_pkg::DEN_W-1:0] s4_rem_ff;
   logic [1:0][sabb_pkg::DEN_W-1:0] s4_den_ff;
   sabb_pkg::side_type         s4_side_ff;

   always_comb begin
      for (int i = 0; i < sabb_pkg::SLABS; i++) begin
         shifted[i] = {6'b0, s3_nmag_ff[i], 8'b0};
         sat_in[i]  = shifted[i] >= s3_dmag_ff[i >> 1];
         nan_in[i]  = (s3_dmag_ff[i >> 1] == '0) && (s3_nmag_ff[i] == '0);
         neg_in[i]  = s3_nneg_ff[i] ^ s3_dneg_ff[i >> 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < sabb_pkg::SLABS; i++) begin
            s4_rem_ff[i] <= sat_in[i] ? '0 : shifted[i];
         end
         s4_den_ff[0]           <= s3_dmag_ff[0];
         s4_den_ff[1]           <= s3_dmag_ff[1];
         s4_side_ff.geo         <= s3_geo_ff;
         s4_side_ff.rvx_mag     <= s3_rvx_mag_ff;
         s4_side_ff.rvy_mag     <= s3_rvy_mag_ff;
         s4_side_ff.rvx_neg     <= s3_rvx_neg_ff;
         s4_side_ff.rvy_neg     <= s3_rvy_neg_ff;
         s4_side_ff.dx_neg      <= s3_dneg_ff[0];
         s4_side_ff.dy_neg      <= s3_dneg_ff[1];
         s4_side_ff.early_miss  <= !s3_active_ff || s3_rv_zero_ff || (nan_in != '0);
         s4_side_ff.sat         <= sat_in;
         s4_side_ff.neg         <= neg_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_rem   = s4_rem_ff;
   assign out_den   = s4_den_ff;
   assign out_side  = s4_side_ff;

endmodule

// ===== sv/sabb_div.sv =====
// ---------------------------------------------------------------------------
// Swept AABB slab divider
// Pipelined restoring division, one quotient bit per stage, four lanes.
// ---------------------------------------------------------------------------
module sabb_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic [sabb_pkg::SLABS-1:0][sabb_pkg::DEN_W-1:0] in_rem,
   input  logic [1:0][sabb_pkg::DEN_W-1:0]       in_den,
   input  sabb_pkg::side_type                    in_side,
   output logic                                  out_valid,
   output logic [sabb_pkg::SLABS-1:0][sabb_pkg::QUO_W-1:0] out_quo,
   output logic [sabb_pkg::SLABS-1:0]            out_rnz,
   output sabb_pkg::side_type                    out_side
);

   localparam int LAST = sabb_pkg::DIV_STEPS - 1;

   logic                                             valid_ff [sabb_pkg::DIV_STEPS];
   logic [sabb_pkg::SLABS-1:0][sabb_pkg::DEN_W-1:0]  rem_ff   [sabb_pkg::DIV_STEPS];
   logic [sabb_pkg::SLABS-1:0][sabb_pkg::QUO_W-1:0]  quo_ff   [sabb_pkg::DIV_STEPS];
   logic [1:0][sabb_pkg::DEN_W-1:0]                  den_ff   [sabb_pkg::DIV_STEPS];
   sabb_pkg::side_type                               side_ff  [sabb_pkg::DIV_STEPS];

   for (genvar k = 0; k < sabb_pkg::DIV_STEPS; k++) begin : g_step
      logic                                            src_valid;
      logic [sabb_pkg::SLABS-1:0][sabb_pkg::DEN_W-1:0] src_rem;
      logic [sabb_pkg::SLABS-1:0][sabb_pkg::QUO_W-1:0] src_quo;
      logic [1:0][sabb_pkg::DEN_W-1:0]                 src_den;
      sabb_pkg::side_type                              src_side;
      logic [sabb_pkg::DEN_W:0]                        dbl   [sabb_pkg::SLABS];
      logic [sabb_pkg::DEN_W:0]                        diff  [sabb_pkg::SLABS];
      logic [sabb_pkg::SLABS-1:0]                      ge;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_rem;
         assign src_quo   = '0;
         assign src_den   = in_den;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_quo   = quo_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      always_comb begin
         for (int j = 0; j < sabb_pkg::SLABS; j++) begin
            dbl[j]  = {src_rem[j], 1'b0};
            diff[j] = dbl[j] - {1'b0, src_den[j >> 1]};
            ge[j]   = dbl[j] >= {1'b0, src_den[j >> 1]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int j = 0; j < sabb_pkg::SLABS; j++) begin
               rem_ff[k][j] <= ge[j] ? diff[j][sabb_pkg::DEN_W-1:0] :
                                       dbl[j][sabb_pkg::DEN_W-1:0];
               quo_ff[k][j] <= {src_quo[j][sabb_pkg::QUO_W-2:0], ge[j]};
            end
            den_ff[k]  <= src_den;
            side_ff[k] <= src_side;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < sabb_pkg::SLABS; j++) begin
         out_rnz[j] = rem_ff[LAST][j] != '0;
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_quo   = quo_ff[LAST];
   assign out_side  = side_ff[LAST];

endmodule

// ===== sv/sabb_resolve.sv =====
// ---------------------------------------------------------------------------
// Swept AABB hit resolution
// Signed slab times, hit test, normal, slide velocity and contact point.
// ---------------------------------------------------------------------------
module sabb_resolve (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic [15:0]                           frame_time,
   input  logic                                  in_valid,
   input  logic [sabb_pkg::SLABS-1:0][sabb_pkg::QUO_W-1:0] in_quo,
   input  logic [sabb_pkg::SLABS-1:0]            in_rnz,
   input  sabb_pkg::side_type                    in_side,
   output logic                                  out_valid,
   output logic                                  out_hit,
   output logic signed [31:0]                    out_new_vx,
   output logic signed [31:0]                    out_new_vy,
   output logic signed [31:0]                    out_contact_x,
   output logic signed [31:0]                    out_contact_y,
   output logic signed [1:0]                     out_normal_x,
   output logic signed [1:0]                     out_normal_y,
   output logic [15:0]                           out_hit_time
);

   // r1: signed slab times, floor toward minus infinity
   logic [31:0]         mag [sabb_pkg::SLABS];
   logic                r1_valid_ff;
   logic signed [31:0]  r1_t_ff [sabb_pkg::SLABS];
   sabb_pkg::side_type  r1_side_ff;

   always_comb begin
      for (int i = 0; i < sabb_pkg::SLABS; i++) begin
         mag[i] = in_side.sat[i] ? sabb_pkg::T_BIG :
                  32'(in_quo[i]) + 32'(in_side.neg[i] & in_rnz[i]);
      end
   end

   // r2: order entry and exit per axis
   logic                r2_valid_ff;
   logic signed [31:0]  r2_tnx_ff, r2_tfx_ff, r2_tny_ff, r2_tfy_ff;
   sabb_pkg::side_type  r2_side_ff;

   // r3: combine axes
   logic                r3_valid_ff;
   logic signed [31:0]  r3_tcn_ff;
   logic                r3_reject_ff, r3_x_first_ff, r3_y_first_ff;
   sabb_pkg::side_type  r3_side_ff;

   // r4: hit, normal, products
   logic                hit_in;
   logic [16:0]         remain;
   logic                r4_valid_ff, r4_hit_ff;
   logic signed [1:0]   r4_nx_ff, r4_ny_ff;
   logic [15:0]         r4_tcn_ff;
   logic [49:0]         r4_slide_x_ff, r4_slide_y_ff;
   logic [31:0]         r4_td_ff;
   sabb_pkg::side_type  r4_side_ff;

   // r5: velocity sum, displacement partial products
   logic [34:0]         sx, sy;
   logic                r5_valid_ff, r5_hit_ff;
   logic signed [1:0]   r5_nx_ff, r5_ny_ff;
   logic [15:0]         r5_tcn_ff;
   logic signed [36:0]  r5_vx_ff, r5_vy_ff;
   logic [47:0]         r5_plo_x_ff, r5_plo_y_ff;
   logic [48:0]         r5_phi_x_ff, r5_phi_y_ff;
   sabb_pkg::side_type  r5_side_ff;

   // r6: saturate velocity, full products
   logic                r6_valid_ff, r6_hit_ff;
   logic signed [1:0]   r6_nx_ff, r6_ny_ff;
   logic [15:0]         r6_tcn_ff;
   logic signed [31:0]  r6_vx_ff, r6_vy_ff;
   logic [63:0]         r6_px_ff, r6_py_ff;
   sabb_pkg::side_type  r6_side_ff;

   // r7: doubled-unit displacement
   logic [36:0]         dpx, dpy;
   logic                r7_valid_ff, r7_hit_ff;
   logic signed [1:0]   r7_nx_ff, r7_ny_ff;
   logic [15:0]         r7_tcn_ff;
   logic signed [31:0]  r7_vx_ff, r7_vy_ff;
   logic signed [36:0]  r7_dx_ff, r7_dy_ff;
   sabb_pkg::side_type  r7_side_ff;

   // r8: contact point, output register
   logic signed [36:0]  sum_x, sum_y;
   logic                r8_valid_ff, r8_hit_ff;
   logic signed [31:0]  r8_vx_ff, r8_vy_ff, r8_cx_ff, r8_cy_ff;
   logic signed [1:0]   r8_nx_ff, r8_ny_ff;
   logic [15:0]         r8_tcn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
         r3_valid_ff <= 1'b0;
         r4_valid_ff <= 1'b0;
         r5_valid_ff <= 1'b0;
         r6_valid_ff <= 1'b0;
         r7_valid_ff <= 1'b0;
         r8_valid_ff <= 1'b0;
      end else if (adv) begin
         r1_valid_ff <= in_valid;
         r2_valid_ff <= r1_valid_ff;
         r3_valid_ff <= r2_valid_ff;
         r4_valid_ff <= r3_valid_ff;
         r5_valid_ff <= r4_valid_ff;
         r6_valid_ff <= r5_valid_ff;
         r7_valid_ff <= r6_valid_ff;
         r8_valid_ff <= r7_valid_ff;
      end
   end

   always_comb begin
      hit_in = !r3_side_ff.early_miss && !r3_reject_ff && !r3_tcn_ff[31] &&
               (r3_tcn_ff < sabb_pkg::T_ONE);
      remain = 17'h10000 - {1'b0, r3_tcn_ff[15:0]};
      sx = 35'(r4_slide_x_ff[49:16]) + 35'(sabb_pkg::PUSH_OUT);
      sy = 35'(r4_slide_y_ff[49:16]) + 35'(sabb_pkg::PUSH_OUT);
      dpx = 37'((65'(r6_px_ff) + 65'h7FFF_FFFF) >> 31);
      dpy = 37'((65'(r6_py_ff) + 65'h7FFF_FFFF) >> 31);
      sum_x = (37'(r7_side_ff.geo.mx) <<< 1) + 37'(r7_side_ff.geo.mw) + r7_dx_ff;
      sum_y = (37'(r7_side_ff.geo.my) <<< 1) + 37'(r7_side_ff.geo.mh) + r7_dy_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // r1
         for (int i = 0; i < sabb_pkg::SLABS; i++) begin
            r1_t_ff[i] <= in_side.neg[i] ? -$signed(mag[i]) : $signed(mag[i]);
         end
         r1_side_ff <= in_side;

         // r2
         if (r1_t_ff[sabb_pkg::SLAB_NX] > r1_t_ff[sabb_pkg::SLAB_FX]) begin
            r2_tnx_ff <= r1_t_ff[sabb_pkg::SLAB_FX];
            r2_tfx_ff <= r1_t_ff[sabb_pkg::SLAB_NX];
         end else begin
            r2_tnx_ff <= r1_t_ff[sabb_pkg::SLAB_NX];
            r2_tfx_ff <= r1_t_ff[sabb_pkg::SLAB_FX];
         end
         if (r1_t_ff[sabb_pkg::SLAB_NY] > r1_t_ff[sabb_pkg::SLAB_FY]) begin
            r2_tny_ff <= r1_t_ff[sabb_pkg::SLAB_FY];
            r2_tfy_ff <= r1_t_ff[sabb_pkg::SLAB_NY];
         end else begin
            r2_tny_ff <= r1_t_ff[sabb_pkg::SLAB_NY];
            r2_tfy_ff <= r1_t_ff[sabb_pkg::SLAB_FY];
         end
         r2_side_ff <= r1_side_ff;

         // r3
         r3_tcn_ff <= (r2_tnx_ff > r2_tny_ff) ? r2_tnx_ff : r2_tny_ff;
         r3_reject_ff <= (r2_tnx_ff > r2_tfy_ff) || (r2_tny_ff > r2_tfx_ff) ||
                         (r2_tfx_ff[31] || r2_tfy_ff[31]) ||
                         (r2_tnx_ff > sabb_pkg::T_ONE) || (r2_tny_ff > sabb_pkg::T_ONE);
         r3_x_first_ff <= r2_tnx_ff > r2_tny_ff;
         r3_y_first_ff <= r2_tnx_ff < r2_tny_ff;
         r3_side_ff <= r2_side_ff;

         // r4: a tie leaves both normal components zero
         r4_hit_ff <= hit_in;
         r4_nx_ff  <= (hit_in && r3_x_first_ff) ?
                      (r3_side_ff.dx_neg ? sabb_pkg::NORM_POS : sabb_pkg::NORM_NEG) :
                      sabb_pkg::NORM_ZERO;
         r4_ny_ff  <= (hit_in && r3_y_first_ff) ?
                      (r3_side_ff.dy_neg ? sabb_pkg::NORM_POS : sabb_pkg::NORM_NEG) :
                      sabb_pkg::NORM_ZERO;
         r4_tcn_ff <= r3_tcn_ff[15:0];
         r4_slide_x_ff <= 50'(r3_side_ff.rvx_mag) * 50'(remain);
         r4_slide_y_ff <= 50'(r3_side_ff.rvy_mag) * 50'(remain);
         r4_td_ff  <= 32'(r3_tcn_ff[15:0]) * 32'(frame_time);
         r4_side_ff <= r3_side_ff;

         // r5
         r5_hit_ff <= r4_hit_ff;
         r5_nx_ff  <= r4_nx_ff;
         r5_ny_ff  <= r4_ny_ff;
         r5_tcn_ff <= r4_tcn_ff;
         r5_vx_ff  <= 37'(r4_side_ff.geo.mvx) +
                      ((r4_nx_ff == sabb_pkg::NORM_POS) ? 37'(sx) :
                       (r4_nx_ff == sabb_pkg::NORM_NEG) ? -37'(sx) : 37'd0);
         r5_vy_ff  <= 37'(r4_side_ff.geo.mvy) +
                      ((r4_ny_ff == sabb_pkg::NORM_POS) ? 37'(sy) :
                       (r4_ny_ff == sabb_pkg::NORM_NEG) ? -37'(sy) : 37'd0);
         r5_plo_x_ff <= 48'(r4_side_ff.rvx_mag[15:0]) * 48'(r4_td_ff);
         r5_plo_y_ff <= 48'(r4_side_ff.rvy_mag[15:0]) * 48'(r4_td_ff);
         r5_phi_x_ff <= 49'(r4_side_ff.rvx_mag[32:16]) * 49'(r4_td_ff);
         r5_phi_y_ff <= 49'(r4_side_ff.rvy_mag[32:16]) * 49'(r4_td_ff);
         r5_side_ff <= r4_side_ff;

         // r6
         r6_hit_ff <= r5_hit_ff;
         r6_nx_ff  <= r5_nx_ff;
         r6_ny_ff  <= r5_ny_ff;
         r6_tcn_ff <= r5_tcn_ff;
         r6_vx_ff  <= sabb_pkg::sat32(r5_vx_ff);
         r6_vy_ff  <= sabb_pkg::sat32(r5_vy_ff);
         r6_px_ff  <= 64'({r5_phi_x_ff, 16'b0}) + 64'(r5_plo_x_ff);
         r6_py_ff  <= 64'({r5_phi_y_ff, 16'b0}) + 64'(r5_plo_y_ff);
         r6_side_ff <= r5_side_ff;

         // r7: round the negative side toward minus infinity
         r7_hit_ff <= r6_hit_ff;
         r7_nx_ff  <= r6_nx_ff;
         r7_ny_ff  <= r6_ny_ff;
         r7_tcn_ff <= r6_tcn_ff;
         r7_vx_ff  <= r6_vx_ff;
         r7_vy_ff  <= r6_vy_ff;
         r7_dx_ff  <= r6_side_ff.rvx_neg ? -$signed(dpx) : $signed(37'(r6_px_ff >> 31));
         r7_dy_ff  <= r6_side_ff.rvy_neg ? -$signed(dpy) : $signed(37'(r6_py_ff >> 31));
         r7_side_ff <= r6_side_ff;

         // r8
         r8_hit_ff <= r7_hit_ff;
         r8_vx_ff  <= r7_hit_ff ? r7_vx_ff : r7_side_ff.geo.mvx;
         r8_vy_ff  <= r7_hit_ff ? r7_vy_ff : r7_side_ff.geo.mvy;
         r8_cx_ff  <= r7_hit_ff ? sabb_pkg::sat32(sum_x >>> 1) : '0;
         r8_cy_ff  <= r7_hit_ff ? sabb_pkg::sat32(sum_y >>> 1) : '0;
         r8_nx_ff  <= r7_nx_ff;
         r8_ny_ff  <= r7_ny_ff;
         r8_tcn_ff <= r7_hit_ff ? r7_tcn_ff : '0;
      end
   end

   assign out_valid     = r8_valid_ff;
   assign out_hit       = r8_hit_ff;
   assign out_new_vx    = r8_vx_ff;
   assign out_new_vy    = r8_vy_ff;
   assign out_contact_x = r8_cx_ff;
   assign out_contact_y = r8_cy_ff;
   assign out_normal_x  = r8_nx_ff;
   assign out_normal_y  = r8_ny_ff;
   assign out_hit_time  = r8_tcn_ff;

endmodule

// ===== sv/swept_aabb_collision_response.sv =====
// ---------------------------------------------------------------------------
// Swept AABB collision response
// Top level: frame time register, setup, slab divider and hit resolution.
// ---------------------------------------------------------------------------
// Each req item carries a moving and a target rectangle; each item gives one
// rsp item with hit flag, slid velocity, contact point, normal and hit time.
// Both channels move an item on a clock edge with valid high and stall low.
// csr_we writes csr_wdata into the frame time register (reset value 1092);
// write it only while no item is in flight.
// The pipeline has 4 setup stages, 24 divider stages (one quotient bit
// per stage, four slab lanes in parallel) and 8 resolution stages, the last
// of which is the rsp output register.
// Throughput is one item per cycle. When the receiver stalls a valid rsp
// item, the whole pipeline holds, bubbles included, and req_stall stays high
// until that item is taken.
// Synchronous reset empties the pipeline and restores the frame time.
// ---------------------------------------------------------------------------
`include "swept_aabb_collision_response_defines.svh"

module swept_aabb_collision_response (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_mover_x,
   input  logic signed [31:0] req_mover_y,
   input  logic [63:0]        req_mover_size,
   input  logic signed [31:0] req_mover_vx,
   input  logic signed [31:0] req_mover_vy,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic [63:0]        req_target_size,
   input  logic signed [31:0] req_target_vx,
   input  logic signed [31:0] req_target_vy,
   input  logic               req_target_active,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_new_vx,
   output logic signed [31:0] rsp_new_vy,
   output logic signed [31:0] rsp_contact_x,
   output logic signed [31:0] rsp_contact_y,
   output logic signed [1:0]  rsp_normal_x,
   output logic signed [1:0]  rsp_normal_y,
   output logic [15:0]        rsp_hit_time
);

   logic [15:0] frame_time_ff;
   logic        adv;

   logic                                                   prep_valid;
   logic [sabb_pkg::SLABS-1:0][sabb_pkg::DEN_W-1:0]        prep_rem;
   logic [1:0][sabb_pkg::DEN_W-1:0]                        prep_den;
   sabb_pkg::side_type                                     prep_side;

   logic                                                   div_valid;
   logic [sabb_pkg::SLABS-1:0][sabb_pkg::QUO_W-1:0]        div_quo;
   logic [sabb_pkg::SLABS-1:0]                             div_rnz;
   sabb_pkg::side_type                                     div_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff <= sabb_pkg::FRAME_TIME_RESET;
      end else if (csr_we) begin
         frame_time_ff <= csr_wdata;
      end
   end

   // hold everything while a finished item waits at the output
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   sabb_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_valid),
      .frame_time    (frame_time_ff),
      .mover_x       (req_mover_x),
      .mover_y       (req_mover_y),
      .mover_size    (req_mover_size),
      .mover_vx      (req_mover_vx),
      .mover_vy      (req_mover_vy),
      .target_x      (req_target_x),
      .target_y      (req_target_y),
      .target_size   (req_target_size),
      .target_vx     (req_target_vx),
      .target_vy     (req_target_vy),
      .target_active (req_target_active),
      .out_valid     (prep_valid),
      .out_rem       (prep_rem),
      .out_den       (prep_den),
      .out_side      (prep_side)
   );

   sabb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (prep_valid),
      .in_rem    (prep_rem),
      .in_den    (prep_den),
      .in_side   (prep_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_rnz   (div_rnz),
      .out_side  (div_side)
   );

   sabb_resolve u_resolve (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .frame_time    (frame_time_ff),
      .in_valid      (div_valid),
      .in_quo        (div_quo),
      .in_rnz        (div_rnz),
      .in_side       (div_side),
      .out_valid     (rsp_valid),
      .out_hit       (rsp_hit),
      .out_new_vx    (rsp_new_vx),
      .out_new_vy    (rsp_new_vy),
      .out_contact_x (rsp_contact_x),
      .out_contact_y (rsp_contact_y),
      .out_normal_x  (rsp_normal_x),
      .out_normal_y  (rsp_normal_y),
      .out_hit_time  (rsp_hit_time)
   );

   `SABB_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_hit_time == '0 && rsp_contact_x == '0 && rsp_contact_y == '0 &&
      rsp_normal_x == '0 && rsp_normal_y == '0)
   `SABB_ASSERT_IMPLY(a_one_normal, clock, reset, rsp_valid && rsp_hit,
      rsp_normal_x == sabb_pkg::NORM_ZERO || rsp_normal_y == sabb_pkg::NORM_ZERO)
   `SABB_ASSERT_IMPLY(a_normal_code, clock, reset, rsp_valid,
      rsp_normal_x != 2'b10 && rsp_normal_y != 2'b10)

endmodule
